// File: design/spct_pkg.sv
package spct_pkg;

    localparam int CoordW    = 24;
    localparam int SizeW     = 23;
    localparam int NormW     = 16;
    localparam int NormFracW = 14;
    localparam int DepthW    = 25;

    typedef enum logic [1:0] {
        OP_RECT_RECT   = 2'd0,
        OP_CIRC_CIRC   = 2'd1,
        OP_CIRC_RECT   = 2'd2,
        OP_RECT_CIRC   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [CoordW-1:0] a_x;
        logic signed [CoordW-1:0] a_y;
        logic [SizeW-1:0]         a_w;
        logic [SizeW-1:0]         a_h;
        logic signed [CoordW-1:0] b_x;
        logic signed [CoordW-1:0] b_y;
        logic [SizeW-1:0]         b_w;
        logic [SizeW-1:0]         b_h;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [NormW-1:0] normal_x;
        logic signed [NormW-1:0] normal_y;
        logic [DepthW-1:0]       depth;
    } rsp_t;

    // Classified request handed from front to back: rect-rect result, circle offset and radius.
    typedef struct packed {
        logic                    round;   // needs distance test
        logic                    box_hit; // rect-rect result
        logic [CoordW:0]         mx;      // |dx|
        logic [CoordW:0]         my;      // |dy|
        logic                    sx;      // dx negative
        logic                    sy;      // dy negative
        logic [SizeW:0]          rad;
    } cls_t;

endpackage

// File: design/spct_front.sv
module spct_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  spct_pkg::req_t in_req,
    output logic           out_valid,
    input  logic           out_ready,
    output spct_pkg::cls_t out_cls,
    output logic           in_ready
);
    import spct_pkg::*;

    logic signed [CoordW+1:0] ax, ay, bx, by, aw, ah, bw, bh;
    logic signed [CoordW+1:0] cx, cy, rx, ry, rx2, ry2, px, py, dx, dy;
    logic [SizeW:0]           rad;
    logic                     box;
    cls_t                     cls;
    logic                     valid_reg, valid_next;
    cls_t                     cls_reg, cls_next;

    always_comb
    begin
        ax = (CoordW+2)'(in_req.a_x);
        ay = (CoordW+2)'(in_req.a_y);
        bx = (CoordW+2)'(in_req.b_x);
        by = (CoordW+2)'(in_req.b_y);
        aw = (CoordW+2)'({1'b0, in_req.a_w});
        ah = (CoordW+2)'({1'b0, in_req.a_h});
        bw = (CoordW+2)'({1'b0, in_req.b_w});
        bh = (CoordW+2)'({1'b0, in_req.b_h});
        box = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
        if (in_req.opcode == OP_RECT_CIRC)
        begin
            cx = bx; cy = by; rx = ax; ry = ay; rx2 = ax + aw; ry2 = ay + ah;
            rad = {1'b0, in_req.b_w};
        end
        else
        begin
            cx = ax; cy = ay; rx = bx; ry = by; rx2 = bx + bw; ry2 = by + bh;
            rad = {1'b0, in_req.a_w};
        end
        if (in_req.opcode == OP_CIRC_CIRC)
        begin
            px = bx; py = by;
            rad = {1'b0, in_req.a_w} + {1'b0, in_req.b_w};
        end
        else
        begin
            px = (cx < rx) ? rx : ((cx > rx2) ? rx2 : cx);
            py = (cy < ry) ? ry : ((cy > ry2) ? ry2 : cy);
        end
        dx = cx - px;
        dy = cy - py;
        cls.round   = (in_req.opcode != OP_RECT_RECT);
        cls.box_hit = box;
        cls.sx      = dx[CoordW+1];
        cls.sy      = dy[CoordW+1];
        cls.mx      = dx[CoordW+1] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
        cls.my      = dy[CoordW+1] ? (CoordW+1)'(-dy) : (CoordW+1)'(dy);
        cls.rad     = rad;
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        cls_next   = cls_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
            cls_next   = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cls_reg <= cls_next;
    end

    assign out_valid = valid_reg;
    assign out_cls   = cls_reg;
endmodule

// File: design/spct_back.sv
module spct_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  spct_pkg::cls_t in_cls,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output spct_pkg::rsp_t out_rsp
);
    import spct_pkg::*;

    // Stages: 0 squares, 1..RtW sqrt iterations (one bit per stage), then
    // QW stages that divide both components, one quotient bit per stage.
    localparam int MW   = CoordW + 1;
    localparam int SqW  = 2 * MW + 1;
    localparam int RtW  = MW + 1;
    localparam int NumW = MW + NormFracW + 1;
    localparam int QW   = NormFracW + 2;
    localparam int NS   = 1 + RtW + QW;

    typedef struct packed {
        logic             round;
        logic             box_hit;
        logic [MW-1:0]    mx;
        logic [MW-1:0]    my;
        logic             sx;
        logic             sy;
        logic [SizeW:0]   rad;
        logic [SqW-1:0]   d2;
        logic [RtW-1:0]   root;
        logic [NumW-1:0]  nx;
        logic [NumW-1:0]  ny;
        logic [QW-1:0]    qx;
        logic [QW-1:0]    qy;
    } stg_t;

    logic [NS-1:0] v_reg;
    stg_t          s_reg [NS];
    stg_t          s_next [NS];
    logic          adv;
    logic          ld;
    logic          ovalid_reg;
    rsp_t          orsp_reg, orsp_next;

    assign ld       = !ovalid_reg || out_ready;
    assign adv      = !v_reg[NS-1] || ld;
    assign in_ready = adv;

    always_comb
    begin
        stg_t t;
        logic [2*MW-1:0]  sq_x;
        logic [2*MW-1:0]  sq_y;
        logic [RtW-1:0]   trial;
        logic [2*RtW-1:0] cand;
        logic [NumW-1:0]  dv;
        logic [NumW-1:0]  half;
        t = '0;
        sq_x = '0;
        sq_y = '0;
        trial = '0;
        cand = '0;
        dv = '0;
        half = '0;
        // stage 0: squares
        t.round   = in_cls.round;
        t.box_hit = in_cls.box_hit;
        t.mx = in_cls.mx; t.my = in_cls.my;
        t.sx = in_cls.sx; t.sy = in_cls.sy;
        t.rad = in_cls.rad;
        sq_x = in_cls.mx * in_cls.mx;
        sq_y = in_cls.my * in_cls.my;
        t.d2 = SqW'(sq_x) + SqW'(sq_y);
        t.root = '0;
        s_next[0] = t;
        // sqrt: restoring, one bit per stage (shift-free candidate compare)
        for (int k = 0; k < RtW; k++)
        begin
            t = s_reg[k];
            trial = t.root | (RtW'(1) << (RtW-1-k));
            cand = trial * trial;
            if (cand <= {1'b0, t.d2})
                t.root = trial;
            if (k == RtW-1)
            begin
                half = NumW'(t.root >> 1);
                t.nx = (NumW'(t.mx) << NormFracW) + half;
                t.ny = (NumW'(t.my) << NormFracW) + half;
                t.qx = '0; t.qy = '0;
            end
            s_next[k+1] = t;
        end
        // divide: quotient bit per stage
        for (int k = 0; k < QW; k++)
        begin
            t = s_reg[RtW+k];
            dv = NumW'(t.root) << (QW-1-k);
            if (t.root != '0 && t.nx >= dv && (NumW'(t.root) == (dv >> (QW-1-k))))
            begin
                t.nx = t.nx - dv;
                t.qx[QW-1-k] = 1'b1;
            end
            if (t.root != '0 && t.ny >= dv && (NumW'(t.root) == (dv >> (QW-1-k))))
            begin
                t.ny = t.ny - dv;
                t.qy[QW-1-k] = 1'b1;
            end
            s_next[RtW+1+k] = t;
        end
    end

    always_comb
    begin
        stg_t f;
        logic [2*SizeW+1:0] r2;
        logic hitc;
        f = s_reg[NS-1];
        r2 = f.rad * f.rad;
        hitc = f.d2 < SqW'(r2);
        orsp_next = orsp_reg;
        if (ld && v_reg[NS-1])
        begin
            orsp_next = '0;
            if (!f.round)
                orsp_next.hit = f.box_hit;
            else if (hitc)
            begin
                orsp_next.hit   = 1'b1;
                orsp_next.depth = DepthW'(f.rad) - DepthW'(f.root);
                if (f.root != '0)
                begin
                    orsp_next.normal_x = f.sx ? NormW'(-f.qx) : NormW'(f.qx);
                    orsp_next.normal_y = f.sy ? NormW'(-f.qy) : NormW'(f.qy);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg      <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                v_reg <= {v_reg[NS-2:0], in_valid};
            if (ld)
                ovalid_reg <= v_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int k = 0; k < NS; k++)
                s_reg[k] <= s_next[k];
        orsp_reg <= orsp_next;
    end

    assign out_valid = ovalid_reg;
    assign out_rsp   = orsp_reg;

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ready |=> ovalid_reg && $stable(orsp_reg))
        else $error("result changed while stalled");
    ap_rr: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !orsp_reg.hit |-> orsp_reg.depth == '0)
        else $error("depth without hit");
    ap_norm: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && orsp_reg.depth == '0 |-> orsp_reg.normal_x == '0)
        else $error("normal without depth");
endmodule

// File: design/shape_pair_collision_test.sv
// Shape pair collision test.
// Input queue: drive req with one shape pair and raise push while full is
// low; the request is taken on that edge. Output queue: while empty is low
// rsp holds the oldest result; raise pop to take it.
// One request per cycle is accepted back to back while results are popped.
// A front stage clamps the circle centre to the rectangle and registers the
// offset; the back stage squares it, extracts the integer square root one
// bit per stage and then divides each offset component by the length one
// quotient bit per stage. Behind the front register come one square stage,
// 26 root stages, 16 divide stages and the result register; throughput is
// one result per cycle while pop is held high.
// A stalled pop holds the result register; the back pipeline keeps
// advancing until its last stage holds a request, then freezes, then the
// front register fills and full rises; nothing is dropped.
// Reset clears all valid flags; payload registers keep their contents.
module shape_pair_collision_test (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  spct_pkg::req_t req,
    output logic           empty,
    input  logic           pop,
    output spct_pkg::rsp_t rsp
);
    import spct_pkg::*;

    logic f_ready, fb_valid, b_ready, b_valid;
    cls_t fb_cls;

    spct_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(push), .in_req(req), .in_ready(f_ready),
        .out_valid(fb_valid), .out_ready(b_ready), .out_cls(fb_cls)
    );

    spct_back u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fb_valid), .in_cls(fb_cls), .in_ready(b_ready),
        .out_valid(b_valid), .out_ready(pop), .out_rsp(rsp)
    );

    assign full  = !f_ready;
    assign empty = !b_valid;
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import spct_pkg::*;

    localparam int LatencyCycles = 80;
    localparam longint CycleLimit = 400000;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    req_t req;
    logic empty;
    logic pop;
    rsp_t rsp;

    // Expected collision results, oldest first.
    rsp_t collision_q[$];
    int errors;
    longint cycle_count;
    int send_idle_pct;
    int recv_idle_pct;

    shape_pair_collision_test uut (
        .clk  (clk),
        .rst_n(rst_n),
        .push (push),
        .full (full),
        .req  (req),
        .empty(empty),
        .pop  (pop),
        .rsp  (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bound the run; a hang ends as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Unsigned magnitude of a signed offset.
    function automatic longint unsigned abs_of(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // Floor integer square root of a squared distance (fits 64 bits here).
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // One normal component, rounded half up, sign restored.
    function automatic logic [NormW-1:0] unit_component(longint d, longint unsigned len);
        longint unsigned q;
        q = ((abs_of(d) << NormFracW) + (len >> 1)) / len;
        if (d < 0)
            q = -q;
        return q[NormW-1:0];
    endfunction

    // Distance test of an offset against a radius.
    function automatic rsp_t distance_test(longint dx, longint dy, longint unsigned r);
        rsp_t res;
        longint unsigned d2;
        longint unsigned len;
        res = '0;
        d2 = abs_of(dx) * abs_of(dx) + abs_of(dy) * abs_of(dy);
        if (d2 < r * r)
        begin
            len = isqrt(d2);
            res.hit = 1'b1;
            if (len != 0)
            begin
                res.normal_x = unit_component(dx, len);
                res.normal_y = unit_component(dy, len);
            end
            res.depth = DepthW'(r - len);
        end
        return res;
    endfunction

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Predict the collision result of one shape pair.
    function automatic rsp_t predict_collision(req_t r);
        rsp_t res;
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint cx, cy, cr, rx, ry, rw, rh;
        res = '0;
        ax = longint'(r.a_x);
        ay = longint'(r.a_y);
        bx = longint'(r.b_x);
        by = longint'(r.b_y);
        aw = longint'({1'b0, r.a_w});
        ah = longint'({1'b0, r.a_h});
        bw = longint'({1'b0, r.b_w});
        bh = longint'({1'b0, r.b_h});
        case (opcode_t'(r.opcode))
            OP_RECT_RECT:
            begin
                res.hit = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);
            end
            OP_CIRC_CIRC:
            begin
                res = distance_test(ax - bx, ay - by, aw + bw);
            end
            default:
            begin
                if (opcode_t'(r.opcode) == OP_CIRC_RECT)
                begin
                    cx = ax; cy = ay; cr = aw; rx = bx; ry = by; rw = bw; rh = bh;
                end
                else
                begin
                    cx = bx; cy = by; cr = bw; rx = ax; ry = ay; rw = aw; rh = ah;
                end
                res = distance_test(cx - clamp_to(cx, rx, rx + rw),
                                    cy - clamp_to(cy, ry, ry + rh), cr);
            end
        endcase
        return res;
    endfunction

    // Send one request, idling at random first; hold it until taken.
    task automatic send_pair(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
        collision_q.push_back(predict_collision(r));
    endtask

    // Drive pop at random and check each accepted result.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (collision_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = collision_q.pop_front();
                    if (rsp.hit !== want.hit)
                    begin
                        $display("%0t: hit expected %b actual %b", $time, want.hit, rsp.hit);
                        errors++;
                    end
                    if (rsp.normal_x !== want.normal_x)
                    begin
                        $display("%0t: normal_x expected %0d actual %0d",
                                 $time, want.normal_x, rsp.normal_x);
                        errors++;
                    end
                    if (rsp.normal_y !== want.normal_y)
                    begin
                        $display("%0t: normal_y expected %0d actual %0d",
                                 $time, want.normal_y, rsp.normal_y);
                        errors++;
                    end
                    if (rsp.depth !== want.depth)
                    begin
                        $display("%0t: depth expected %0d actual %0d",
                                 $time, want.depth, rsp.depth);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [CoordW-1:0] rand_coord();
        case ($urandom_range(3))
            0: return CoordW'($urandom);
            default: return CoordW'($signed($urandom_range(8000)) - 4000);
        endcase
    endfunction

    function automatic logic [SizeW-1:0] rand_size();
        case ($urandom_range(4))
            0: return SizeW'($urandom);
            1: return '0;
            default: return SizeW'($urandom_range(3000));
        endcase
    endfunction

    function automatic req_t rand_pair();
        req_t r;
        r.opcode = 2'($urandom_range(3));
        r.a_x = rand_coord();
        r.a_y = rand_coord();
        r.a_w = rand_size();
        r.a_h = rand_size();
        r.b_x = rand_coord();
        r.b_y = rand_coord();
        r.b_w = rand_size();
        r.b_h = rand_size();
        // Pull two pairs in three close together so hits are common.
        if ($urandom_range(2) != 0)
        begin
            r.b_x = r.a_x + CoordW'($signed($urandom_range(2000)) - 1000);
            r.b_y = r.a_y + CoordW'($signed($urandom_range(2000)) - 1000);
        end
        return r;
    endfunction

    function automatic req_t make_pair(opcode_t op, int ax, int ay, int aw, int ah,
                                       int bx, int by, int bw, int bh);
        req_t r;
        r.opcode = op;
        r.a_x = CoordW'(ax); r.a_y = CoordW'(ay);
        r.a_w = SizeW'(aw);  r.a_h = SizeW'(ah);
        r.b_x = CoordW'(bx); r.b_y = CoordW'(by);
        r.b_w = SizeW'(bw);  r.b_h = SizeW'(bh);
        return r;
    endfunction

    // Extremes, every operation, zero distance, zero-sized rectangles.
    task automatic test_directed();
        int cmax;
        int cmin;
        int smax;
        cmax = 8388607;
        cmin = -8388608;
        smax = 8388607;
        send_pair(make_pair(OP_RECT_RECT, 0, 0, 100, 100, 50, 50, 100, 100));
        send_pair(make_pair(OP_RECT_RECT, 0, 0, 100, 100, 100, 0, 10, 10));
        send_pair(make_pair(OP_RECT_RECT, 10, 10, 0, 0, 0, 0, 100, 100));
        send_pair(make_pair(OP_RECT_RECT, cmin, cmin, smax, smax, cmax, cmax, smax, smax));
        send_pair(make_pair(OP_CIRC_CIRC, 0, 0, 300, 0, 0, 0, 200, 0));
        send_pair(make_pair(OP_CIRC_CIRC, 100, 50, 300, 0, 0, 0, 200, 0));
        send_pair(make_pair(OP_CIRC_CIRC, 0, 0, 100, 0, 200, 0, 100, 0));
        send_pair(make_pair(OP_CIRC_CIRC, cmax, cmax, smax, smax, cmin, cmin, smax, smax));
        send_pair(make_pair(OP_CIRC_CIRC, cmin, cmax, smax, 0, cmax, cmin, smax, 0));
        send_pair(make_pair(OP_CIRC_CIRC, -5, 7, 20, 0, 3, -2, 0, 0));
        send_pair(make_pair(OP_CIRC_RECT, 50, 50, 30, 0, 0, 0, 100, 100));
        send_pair(make_pair(OP_CIRC_RECT, -20, 50, 30, 0, 0, 0, 100, 100));
        send_pair(make_pair(OP_CIRC_RECT, 120, 120, 40, 0, 0, 0, 100, 100));
        send_pair(make_pair(OP_CIRC_RECT, 0, 0, 10, 0, 0, 0, 0, 0));
        send_pair(make_pair(OP_CIRC_RECT, cmax, cmin, smax, smax, cmin, cmax, smax, smax));
        send_pair(make_pair(OP_RECT_CIRC, 0, 0, 100, 100, 110, -10, 20, 0));
        send_pair(make_pair(OP_RECT_CIRC, 0, 0, 0, 100, 5, 50, 10, 0));
        send_pair(make_pair(OP_RECT_CIRC, cmin, cmin, smax, smax, cmax, cmax, smax, smax));
        send_pair(make_pair(OP_RECT_CIRC, 0, 0, 100, 100, -3, -4, 10, 0));
    endtask

    // Random pairs under one idling pattern.
    task automatic test_random(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < count; i++)
            send_pair(rand_pair());
    endtask

    initial
    begin
        int wait_cycles;
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 8;
        recv_idle_pct = 68;
        push = 1'b0;
        pop = 1'b0;
        req = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(380, 8, 68);
        test_random(380, 68, 8);
        test_random(390, 0, 0);
        push <= 1'b0;
        // Drain, then allow stragglers to show up.
        wait_cycles = 0;
        while (collision_q.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LatencyCycles) @(posedge clk);
        if (errors == 0 && collision_q.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule

// File: shape_pair_collision_test.f
design/spct_pkg.sv
design/spct_front.sv
design/spct_back.sv
design/shape_pair_collision_test.sv
tb/sv/testbench.sv
